/* rtl/core/kt_pkg.sv */
// shared types and constants for the key table block
`default_nettype none

package kt_pkg;

    // default sizes
    localparam int DEPTH_DEF     = 1024;
    localparam int KEY_WIDTH_DEF = 32;

    // fixed field widths of the transactions
    localparam int IN_KEY_W = 32;
    localparam int POS_W    = 10;
    localparam int WC_W     = 11;
    localparam int CAP_W    = 11;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORDERED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_METHOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAP     = 2'd2;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // search method codes
    localparam logic [1:0] METH_BINARY    = 2'd0;
    localparam logic [1:0] METH_LINEAR    = 2'd1;
    localparam logic [1:0] METH_TRANSPOSE = 2'd2;

    // reset values of the registers
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef struct packed {
        logic                       operation;
        logic signed [IN_KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic             status;
        logic             found;
        logic [POS_W-1:0] position;
        logic [WC_W-1:0]  work_count;
    } rsp_t;

    // control from the sequencer to the ring
    typedef struct packed {
        logic tail_alt;   // tail takes the alternate value instead of the tap
        logic fix_en;     // second to last cell takes the fix value
    } ring_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_INS_SHIFT,
        ST_LIN,
        ST_BIN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* rtl/core/kt_cell.sv */
// one storage cell of the rotating key ring
`default_nettype none

module kt_cell #(
    parameter int KEY_WIDTH = kt_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic [KEY_WIDTH-1:0] shift_in,
    input  wire logic                 load_en,
    input  wire logic [KEY_WIDTH-1:0] load_val,
    output logic      [KEY_WIDTH-1:0] data
);

    logic [KEY_WIDTH-1:0] data_reg;
    logic [KEY_WIDTH-1:0] data_next;

    // take the neighbor's entry unless overridden
    always_comb
    begin
        data_next = load_en ? load_val : shift_in;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* rtl/core/kt_ring.sv */
// ring of key cells that rotates by one entry every cycle
`default_nettype none

module kt_ring #(
    parameter int DEPTH     = kt_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = kt_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire kt_pkg::ring_ctl_t    ctl,
    input  wire logic [KEY_WIDTH-1:0] alt_val,
    input  wire logic [KEY_WIDTH-1:0] fix_val,
    output logic      [KEY_WIDTH-1:0] tap
);

    logic [KEY_WIDTH-1:0] cell_q [DEPTH];
    logic [KEY_WIDTH-1:0] tail;

    // entry leaving the head re-enters at the tail, or is replaced
    always_comb
    begin
        tail = ctl.tail_alt ? alt_val : cell_q[0];
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            kt_cell #(
                .KEY_WIDTH(KEY_WIDTH)
            ) u_cell (
                .clk      (clk),
                .shift_in ((gi == DEPTH - 1) ? tail : cell_q[(gi + 1) % DEPTH]),
                .load_en  ((gi == DEPTH - 2) ? ctl.fix_en : 1'b0),
                .load_val (fix_val),
                .data     (cell_q[gi])
            );
        end
    endgenerate

    assign tap = cell_q[0];

endmodule

`default_nettype wire

/* rtl/core/key_table_insert_and_search.sv */
// top level: key table with ordered or append insert and three search methods
//
//  port group   direction  handshake              payload
//  req          in         req_valid / req_ready  kt_pkg::req_t (operation, key)
//  rsp          out        rsp_valid / rsp_ready  kt_pkg::rsp_t (status, found, position, work_count)
//  cfg          in         cfg_we                 cfg_index, cfg_data
//
// the table lives in a ring of DEPTH cells that rotates one entry per cycle; the head
// cell is the only read, and writes go in at the tail or, for a transpose swap, also at
// the second to last cell, so every access waits for its entry. linear search waits for
// its first entry to come around, then scans in order; ordered insert makes a scan pass
// and then a shift pass; binary search makes one probe each time its entry comes around.
// reset zeroes the fill count and presets the registers; the ring needs no clearing pass.
// one transaction is in work at a time; a finished result waits in the output register.
`default_nettype none

module key_table_insert_and_search #(
    parameter int DEPTH     = kt_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = kt_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire kt_pkg::req_t                  req,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output kt_pkg::rsp_t                       rsp,
    input  wire logic                          cfg_we,
    input  wire logic [kt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kt_pkg::CFG_W-1:0]      cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = CW + 2;

    // control registers
    kt_pkg::state_t               state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic                         ordered_reg, ordered_next;
    logic [1:0]                   method_reg, method_next;
    logic [kt_pkg::CAP_W-1:0]     cap_reg, cap_next;
    logic [AW-1:0]                ptr_reg, ptr_next;
    logic                         rsp_valid_reg, rsp_valid_next;

    // payload registers
    logic signed [KEY_WIDTH-1:0]  key_reg, key_next;
    logic signed [KEY_WIDTH-1:0]  carry_reg, carry_next;
    logic signed [KEY_WIDTH-1:0]  prev_reg, prev_next;
    logic [CW-1:0]                idx_reg, idx_next;
    logic [CW-1:0]                p_reg, p_next;
    logic [CW-1:0]                cmp_reg, cmp_next;
    logic signed [LW-1:0]         lo_reg, lo_next;
    logic signed [LW-1:0]         hi_reg, hi_next;
    kt_pkg::rsp_t                 res_reg, res_next;
    kt_pkg::rsp_t                 rsp_reg, rsp_next;

    // ring interface
    kt_pkg::ring_ctl_t            ring_ctl;
    logic [KEY_WIDTH-1:0]         ring_alt;
    logic [KEY_WIDTH-1:0]         ring_fix;
    logic [KEY_WIDTH-1:0]         tap_raw;
    logic signed [KEY_WIDTH-1:0]  tap;

    // derived conditions
    logic signed [63:0]           key_wide;
    logic signed [KEY_WIDTH-1:0]  key_in;
    logic [31:0]                  cap32;
    logic [31:0]                  limit;
    logic                         full;
    logic                         accept;
    logic                         hit;
    logic                         eq;
    logic                         gt;
    logic                         last_entry;
    logic                         out_free;
    logic [CW-1:0]                cmp_inc;
    logic signed [LW-1:0]         lo_new;
    logic signed [LW-1:0]         hi_new;
    logic signed [LW-1:0]         mid_sum;
    logic signed [LW-1:0]         hi_init;
    logic [CW-1:0]                p_scan;

    kt_ring #(
        .DEPTH    (DEPTH),
        .KEY_WIDTH(KEY_WIDTH)
    ) u_ring (
        .clk     (clk),
        .ctl     (ring_ctl),
        .alt_val (ring_alt),
        .fix_val (ring_fix),
        .tap     (tap_raw)
    );

    // shared conditions
    always_comb
    begin
        key_wide   = 64'(req.key);
        key_in     = key_wide[KEY_WIDTH-1:0];
        tap        = tap_raw;
        cap32      = 32'(cap_reg);
        limit      = (cap32 > 32'(DEPTH)) ? 32'(DEPTH) : cap32;
        full       = (32'(count_reg) >= limit);
        accept     = req_valid && (state_reg == kt_pkg::ST_IDLE);
        hit        = (ptr_reg == idx_reg[AW-1:0]);
        eq         = (tap == key_reg);
        gt         = (tap > key_reg);
        last_entry = (idx_reg == count_reg - CW'(1));
        out_free   = !rsp_valid_reg || rsp_ready;
        cmp_inc    = cmp_reg + CW'(1);
        lo_new     = gt ? lo_reg : (LW'(idx_reg) + LW'(1));
        hi_new     = gt ? (LW'(idx_reg) - LW'(1)) : hi_reg;
        mid_sum    = (lo_new + hi_new) >>> 1;
        hi_init    = LW'(count_reg) - LW'(1);
        p_scan     = gt ? p_reg : (idx_reg + CW'(1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kt_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.operation == kt_pkg::OP_INSERT)
                    begin
                        if (full)
                            state_next = kt_pkg::ST_DONE;
                        else if (ordered_reg && count_reg != '0)
                            state_next = kt_pkg::ST_INS_SCAN;
                        else
                            state_next = kt_pkg::ST_INS_SHIFT;
                    end
                    else
                    begin
                        if (count_reg == '0)
                            state_next = kt_pkg::ST_DONE;
                        else if (method_reg == kt_pkg::METH_BINARY)
                            state_next = kt_pkg::ST_BIN;
                        else
                            state_next = kt_pkg::ST_LIN;
                    end
                end
            end
            kt_pkg::ST_INS_SCAN:
            begin
                if (hit && last_entry)
                    state_next = kt_pkg::ST_INS_SHIFT;
            end
            kt_pkg::ST_INS_SHIFT:
            begin
                if (hit && idx_reg == count_reg)
                    state_next = kt_pkg::ST_DONE;
            end
            kt_pkg::ST_LIN:
            begin
                if (hit && (eq || last_entry))
                    state_next = kt_pkg::ST_DONE;
            end
            kt_pkg::ST_BIN:
            begin
                if (hit && (eq || lo_new > hi_new))
                    state_next = kt_pkg::ST_DONE;
            end
            kt_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = kt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = kt_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and ring control
    always_comb
    begin
        count_next   = count_reg;
        key_next     = key_reg;
        carry_next   = carry_reg;
        prev_next    = prev_reg;
        idx_next     = idx_reg;
        p_next       = p_reg;
        cmp_next     = cmp_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        res_next     = res_reg;
        rsp_next     = rsp_reg;
        ring_ctl     = '0;
        ring_alt     = carry_reg;
        ring_fix     = tap;
        ptr_next     = (ptr_reg == AW'(DEPTH - 1)) ? '0 : ptr_reg + AW'(1);

        // output register
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (state_reg == kt_pkg::ST_DONE && out_free)
        begin
            rsp_next       = res_reg;
            rsp_valid_next = 1'b1;
        end

        case (state_reg)
            kt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    key_next = key_in;
                    res_next = '0;
                    cmp_next = '0;
                    if (req.operation == kt_pkg::OP_INSERT)
                    begin
                        res_next.status = full;
                        if (ordered_reg && count_reg != '0)
                        begin
                            idx_next = '0;
                            p_next   = '0;
                        end
                        else
                        begin
                            idx_next = count_reg;
                            p_next   = count_reg;
                        end
                    end
                    else
                    begin
                        res_next.status = (count_reg == '0);
                        lo_next         = '0;
                        hi_next         = hi_init;
                        if (method_reg == kt_pkg::METH_BINARY)
                            idx_next = CW'(hi_init >>> 1);
                        else
                            idx_next = '0;
                    end
                end
            end
            kt_pkg::ST_INS_SCAN:
            begin
                // find where the trailing run of larger entries starts
                if (hit)
                begin
                    p_next = p_scan;
                    if (last_entry)
                        idx_next = p_scan;
                    else
                        idx_next = idx_reg + CW'(1);
                end
            end
            kt_pkg::ST_INS_SHIFT:
            begin
                // write the key at its slot and move later entries up by one
                if (hit)
                begin
                    ring_ctl.tail_alt = 1'b1;
                    ring_alt          = (idx_reg == p_reg) ? key_reg : carry_reg;
                    carry_next        = tap;
                    idx_next          = idx_reg + CW'(1);
                    if (idx_reg == count_reg)
                    begin
                        count_next          = count_reg + CW'(1);
                        res_next.work_count = kt_pkg::WC_W'(count_reg - p_reg);
                    end
                end
            end
            kt_pkg::ST_LIN:
            begin
                // one entry a cycle from the front
                if (hit)
                begin
                    prev_next = tap;
                    idx_next  = idx_reg + CW'(1);
                    if (eq)
                    begin
                        res_next.found      = 1'b1;
                        res_next.work_count = kt_pkg::WC_W'(idx_reg + CW'(1));
                        res_next.position   = kt_pkg::POS_W'(idx_reg);
                        if (method_reg == kt_pkg::METH_TRANSPOSE && idx_reg != '0)
                        begin
                            // swap the hit with the entry just ahead of it
                            ring_ctl.tail_alt = 1'b1;
                            ring_alt          = prev_reg;
                            ring_ctl.fix_en   = 1'b1;
                            ring_fix          = tap;
                            res_next.position = kt_pkg::POS_W'(idx_reg - CW'(1));
                        end
                    end
                    else if (last_entry)
                    begin
                        res_next.work_count = kt_pkg::WC_W'(count_reg);
                    end
                end
            end
            kt_pkg::ST_BIN:
            begin
                // one probe each time the middle entry comes around
                if (hit)
                begin
                    cmp_next = cmp_inc;
                    lo_next  = lo_new;
                    hi_next  = hi_new;
                    idx_next = CW'(mid_sum);
                    if (eq)
                    begin
                        res_next.found      = 1'b1;
                        res_next.position   = kt_pkg::POS_W'(idx_reg);
                        res_next.work_count = kt_pkg::WC_W'(cmp_inc);
                    end
                    else if (lo_new > hi_new)
                    begin
                        res_next.work_count = kt_pkg::WC_W'(cmp_inc);
                    end
                end
            end
            kt_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // configuration writes
    always_comb
    begin
        ordered_next = ordered_reg;
        method_next  = method_reg;
        cap_next     = cap_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                kt_pkg::REG_ORDERED: ordered_next = cfg_data[0];
                kt_pkg::REG_METHOD:  method_next  = cfg_data[1:0];
                kt_pkg::REG_CAP:     cap_next     = cfg_data[kt_pkg::CAP_W-1:0];
                default:             ordered_next = ordered_reg;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kt_pkg::ST_IDLE;
            count_reg     <= '0;
            ordered_reg   <= 1'b1;
            method_reg    <= kt_pkg::METH_BINARY;
            cap_reg       <= kt_pkg::CAP_RESET;
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ordered_reg   <= ordered_next;
            method_reg    <= method_next;
            cap_reg       <= cap_next;
            ptr_reg       <= ptr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        carry_reg <= carry_next;
        prev_reg  <= prev_next;
        idx_reg   <= idx_next;
        p_reg     <= p_next;
        cmp_reg   <= cmp_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

    assign req_ready = (state_reg == kt_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // fill count never passes the ring size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(DEPTH))
        else $error("fill count above depth");

    // fill count only moves at the end of an insert
    a_count_move: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == kt_pkg::ST_INS_SHIFT))
        else $error("fill count changed outside insert");

    // an error result carries no other information
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status) |-> (!rsp.found && rsp.work_count == '0
                                       && rsp.position == '0))
        else $error("error result with payload");

    // a result is only loaded after the work is finished
    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> ($past(state_reg) == kt_pkg::ST_DONE))
        else $error("result loaded outside done");

endmodule

`default_nettype wire
